>>> rtl/sbad_pkg.sv
// ----------------------------------------------------------------------------
// sbad_pkg
// Shared types and constants of the segment bus access decoder.
// ----------------------------------------------------------------------------
package sbad_pkg;

  // Store geometry; both depths are powers of two so an index wraps by truncation
  localparam int unsigned RAM_WORDS     = 524288;
  localparam int unsigned RAM_AW        = $clog2(RAM_WORDS);
  localparam int unsigned SCRATCH_WORDS = 256;
  localparam int unsigned SCR_AW        = $clog2(SCRATCH_WORDS);

  // Address map
  localparam logic [31:0] PHYS_MASK   = 32'h1FFF_FFFF;
  localparam logic [31:0] RAM_END     = 32'h0020_0000;
  localparam logic [31:0] MIRROR_LAST = 32'h007F_FFFF;
  localparam logic [31:0] SCR_BASE    = 32'h1F80_0000;
  localparam logic [31:0] SCR_END     = 32'h1F80_0400;
  localparam logic [31:0] IO_BASE     = 32'h1F80_1000;
  localparam logic [31:0] IO_END      = 32'h1F80_2000;
  localparam logic [31:0] BIOS_BASE   = 32'h1FC0_0000;
  localparam logic [31:0] BIOS_END    = 32'h1FC8_0000;

  localparam logic [2:0] SEG_KSEG0 = 3'b100;
  localparam logic [2:0] SEG_KSEG1 = 3'b101;

  typedef enum logic {
    KIND_READ  = 1'b0,
    KIND_WRITE = 1'b1
  } sbad_kind_e;

  typedef enum logic [1:0] {
    SZ_BYTE = 2'd0,
    SZ_HALF = 2'd1,
    SZ_WORD = 2'd2
  } sbad_size_e;

  typedef enum logic [2:0] {
    ST_LOCAL     = 3'd0,
    ST_BIOS_RD   = 3'd1,
    ST_IO        = 3'd2,
    ST_MISALIGN  = 3'd3,
    ST_UNMAPPED  = 3'd4,
    ST_ROM_WRITE = 3'd5
  } sbad_status_e;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_MAIN = 2'd1,
    TGT_SCR  = 2'd2
  } sbad_tgt_e;

  // Decoded access, carried from acceptance to the store stage
  typedef struct packed {
    logic                write;
    sbad_status_e        status;
    sbad_tgt_e           tgt;
    logic [RAM_AW-1:0]   idx;
    logic [31:0]         lanes;
    logic [4:0]          shift;
    logic [4:0]          lane_shift;
    logic [28:0]         ext_address;
    logic [31:0]         rdata;
    logic [31:0]         wdata;
  } sbad_dec_t;

  // Last store write, for forwarding to a read issued in the same cycle
  typedef struct packed {
    logic              valid;
    sbad_tgt_e         tgt;
    logic [RAM_AW-1:0] idx;
    logic [31:0]       word;
  } sbad_byp_t;

endpackage

>>> rtl/sbad_req_if.sv
// ----------------------------------------------------------------------------
// sbad_req_if
// Bus access request channel: valid/ready handshake with the access fields.
// ----------------------------------------------------------------------------
interface sbad_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [1:0]  access_size;
  logic [31:0] virt_address;
  logic [31:0] write_data;

  modport source (output valid, kind, access_size, virt_address, write_data,
                  input ready);
  modport sink   (input valid, kind, access_size, virt_address, write_data,
                  output ready);
endinterface

>>> rtl/sbad_rsp_if.sv
// ----------------------------------------------------------------------------
// sbad_rsp_if
// Bus access response channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface sbad_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [2:0]  status;
  logic [28:0] ext_address;
  logic [4:0]  lane_shift;

  modport source (output valid, read_data, status, ext_address, lane_shift,
                  input ready);
  modport sink   (input valid, read_data, status, ext_address, lane_shift,
                  output ready);
endinterface

>>> rtl/sbad_decode.sv
// ----------------------------------------------------------------------------
// sbad_decode
// Alignment check, segment stripping and address map lookup of one access.
// ----------------------------------------------------------------------------
module sbad_decode import sbad_pkg::*; (
  input  logic        kind_i,
  input  logic [1:0]  access_size_i,
  input  logic [31:0] virt_address_i,
  input  logic [31:0] write_data_i,
  output sbad_dec_t   dec_o
);

  logic [31:0] phys;
  logic [31:0] lanes;
  logic [4:0]  shift;
  logic        size_ok;
  logic        misalign;
  logic        wr;

  always_comb begin
    wr = (kind_i == KIND_WRITE);

    if ((virt_address_i[31:29] == SEG_KSEG0) || (virt_address_i[31:29] == SEG_KSEG1) ||
        (virt_address_i[31:30] == 2'b00)) begin
      phys = virt_address_i & PHYS_MASK;
    end else begin
      phys = virt_address_i;
    end

    size_ok  = 1'b1;
    misalign = 1'b0;
    case (access_size_i)
      SZ_BYTE: begin
        lanes = 32'h0000_00FF;
        shift = {phys[1:0], 3'b000};
      end
      SZ_HALF: begin
        lanes    = 32'h0000_FFFF;
        shift    = {phys[1], 4'b0000};
        misalign = virt_address_i[0];
      end
      SZ_WORD: begin
        lanes    = 32'hFFFF_FFFF;
        shift    = 5'd0;
        misalign = |virt_address_i[1:0];
      end
      default: begin
        lanes   = 32'hFFFF_FFFF;
        shift   = 5'd0;
        size_ok = 1'b0;
      end
    endcase

    dec_o             = '0;
    dec_o.write       = wr;
    dec_o.status      = ST_LOCAL;
    dec_o.tgt         = TGT_NONE;
    dec_o.lanes       = lanes;
    dec_o.shift       = shift;
    dec_o.wdata       = write_data_i;

    if (!size_ok) begin
      dec_o.status = ST_UNMAPPED;
      dec_o.rdata  = wr ? 32'd0 : 32'hFFFF_FFFF;
    end else if (misalign) begin
      dec_o.status = ST_MISALIGN;
      dec_o.rdata  = wr ? 32'd0 : lanes;
    end else if ((phys < RAM_END) ||
                 ((phys <= MIRROR_LAST) && (wr || (access_size_i == SZ_WORD)))) begin
      // fold the mirror onto the base 2 MB
      dec_o.tgt = TGT_MAIN;
      dec_o.idx = RAM_AW'(phys[20:2]);
    end else if ((phys >= SCR_BASE) && (phys < SCR_END)) begin
      dec_o.tgt = TGT_SCR;
      dec_o.idx = RAM_AW'(SCR_AW'(phys[9:2]));
    end else if ((phys >= IO_BASE) && (phys < IO_END)) begin
      dec_o.status      = ST_IO;
      dec_o.ext_address = {phys[28:2], 2'b00};
      dec_o.lane_shift  = shift;
    end else if ((phys >= BIOS_BASE) && (phys < BIOS_END)) begin
      if (wr) begin
        dec_o.status = ST_ROM_WRITE;
      end else begin
        dec_o.status      = ST_BIOS_RD;
        dec_o.ext_address = {10'd0, phys[18:2], 2'b00};
        dec_o.lane_shift  = shift;
      end
    end else begin
      dec_o.status = ST_UNMAPPED;
      dec_o.rdata  = wr ? 32'd0 : lanes;
    end
  end

endmodule

>>> rtl/segment_bus_access_decoder.sv
// ----------------------------------------------------------------------------
// segment_bus_access_decoder
// Bus access decoder with local main RAM and scratchpad word stores.
// ----------------------------------------------------------------------------
// After reset the block sweeps both stores to zero, one word per cycle, over
// all RAM_WORDS (524288) indices and accepts no request until the sweep is
// done. From then on it takes one access per cycle unless the response side
// stalls: the request is decoded and the store read issued in the cycle it
// is accepted; the store stage then merges the byte lanes, writes the word
// back and loads the response register. The registered read port of each
// store sets this split; a write forwarded from the previous access covers
// a read of the same word in back-to-back accesses. BIOS reads and I/O
// accesses are not served here: they return status with the external
// address and lane shift for the system to complete.
module segment_bus_access_decoder import sbad_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  sbad_req_if.sink       req_i,
  sbad_rsp_if.source     rsp_o
);

  logic [31:0] main_mem [RAM_WORDS];
  logic [31:0] scr_mem  [SCRATCH_WORDS];
  logic [31:0] main_rdata_q;
  logic [31:0] scr_rdata_q;

  logic              clearing_q, clearing_d;
  logic [RAM_AW-1:0] clr_cnt_q, clr_cnt_d;

  sbad_dec_t dec;
  sbad_dec_t s1_q;
  logic      s1_valid_q, s1_valid_d;
  sbad_byp_t byp_q, byp_d;

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_rdata_q;
  logic [2:0]  out_status_q;
  logic [28:0] out_ext_q;
  logic [4:0]  out_lsh_q;

  logic        accept;
  logic        advance;
  logic        fwd_hit;
  logic [31:0] cur_word;
  logic [31:0] extract;
  logic [31:0] wmask;
  logic [31:0] new_word;
  logic [31:0] rd_result;
  logic        local_wr;

  logic              main_we, scr_we;
  logic [RAM_AW-1:0] main_waddr;
  logic [SCR_AW-1:0] scr_waddr;
  logic [31:0]       main_wdata, scr_wdata;
  logic              main_re, scr_re;

  sbad_decode u_decode (
    .kind_i         (req_i.kind),
    .access_size_i  (req_i.access_size),
    .virt_address_i (req_i.virt_address),
    .write_data_i   (req_i.write_data),
    .dec_o          (dec)
  );

  // Handshake
  assign advance     = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !clearing_q && (!s1_valid_q || advance);
  assign accept      = req_i.valid && req_i.ready;

  // Store stage: merge lanes on the word read in the accept cycle
  always_comb begin
    fwd_hit  = byp_q.valid && (byp_q.tgt == s1_q.tgt) && (byp_q.idx == s1_q.idx);
    cur_word = fwd_hit ? byp_q.word :
               ((s1_q.tgt == TGT_MAIN) ? main_rdata_q : scr_rdata_q);
    extract  = (cur_word >> s1_q.shift) & s1_q.lanes;
    wmask    = s1_q.lanes << s1_q.shift;
    new_word = (cur_word & ~wmask) | ((s1_q.wdata << s1_q.shift) & wmask);
    if (s1_q.tgt != TGT_NONE) begin
      rd_result = s1_q.write ? 32'd0 : extract;
    end else begin
      rd_result = s1_q.rdata;
    end
    local_wr = advance && s1_q.write && (s1_q.tgt != TGT_NONE);
  end

  // Memory port control
  always_comb begin
    main_re    = accept && (dec.tgt == TGT_MAIN);
    scr_re     = accept && (dec.tgt == TGT_SCR);
    main_we    = clearing_q || (local_wr && (s1_q.tgt == TGT_MAIN));
    scr_we     = clearing_q || (local_wr && (s1_q.tgt == TGT_SCR));
    main_waddr = clearing_q ? clr_cnt_q : s1_q.idx;
    scr_waddr  = clearing_q ? clr_cnt_q[SCR_AW-1:0] : s1_q.idx[SCR_AW-1:0];
    main_wdata = clearing_q ? 32'd0 : new_word;
    scr_wdata  = clearing_q ? 32'd0 : new_word;
  end

  always_ff @(posedge clk_i) begin
    if (main_we) begin
      main_mem[main_waddr] <= main_wdata;
    end
    if (main_re) begin
      main_rdata_q <= main_mem[dec.idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (scr_we) begin
      scr_mem[scr_waddr] <= scr_wdata;
    end
    if (scr_re) begin
      scr_rdata_q <= scr_mem[dec.idx[SCR_AW-1:0]];
    end
  end

  // Next-state logic
  always_comb begin
    clearing_d = clearing_q;
    clr_cnt_d  = clr_cnt_q;
    if (clearing_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == RAM_AW'(RAM_WORDS - 1)) begin
        clearing_d = 1'b0;
      end
    end

    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    byp_d = byp_q;
    if (local_wr) begin
      byp_d.valid = 1'b1;
      byp_d.tgt   = s1_q.tgt;
      byp_d.idx   = s1_q.idx;
      byp_d.word  = new_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      byp_q       <= '0;
    end else begin
      clearing_q  <= clearing_d;
      clr_cnt_q   <= clr_cnt_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      byp_q       <= byp_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= dec;
    end
    if (advance) begin
      out_rdata_q  <= rd_result;
      out_status_q <= s1_q.status;
      out_ext_q    <= s1_q.ext_address;
      out_lsh_q    <= s1_q.lane_shift;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.read_data   = out_rdata_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.ext_address = out_ext_q;
  assign rsp_o.lane_shift  = out_lsh_q;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the segment bus access decoder. A scoreboard keeps
// its own image of main RAM and scratchpad and decodes every accepted access
// into the response it must produce; responses are compared field by field,
// in order. Directed accesses cover the segment masks, every region and its
// boundaries, misalignment and the reserved size code; random accesses then
// mix reads and writes over small RAM windows so reads find written data.
// ----------------------------------------------------------------------------
module tb_top;
  import sbad_pkg::*;

  localparam logic [1:0]  SZ_RSVD      = 2'd3;
  localparam logic [31:0] MIRROR_MASK  = 32'h001F_FFFF;
  localparam logic [31:0] KUSEG_HI     = 32'h2000_0000;
  localparam logic [31:0] KSEG0_BASE   = 32'h8000_0000;
  localparam logic [31:0] KSEG1_BASE   = 32'hA000_0000;
  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned MAX_REPORTS  = 50;

  typedef struct {
    logic [31:0]  read_data;
    sbad_status_e status;
    logic [28:0]  ext_address;
    logic [4:0]   lane_shift;
  } access_rsp_t;

  typedef enum int {
    ZONE_RAM, ZONE_MIRROR, ZONE_SCRATCH, ZONE_IO, ZONE_BIOS, ZONE_BOUNDARY, ZONE_ANY
  } addr_zone_e;

  class access_ledger;
    logic [31:0]  ram_image [int unsigned];
    logic [31:0]  scratch_image [SCRATCH_WORDS];
    access_rsp_t  pending_rsp[$];
    int unsigned  errors;
    int unsigned  checked;
    int unsigned  writes;
    int unsigned  status_seen [8];

    function new();
      foreach (scratch_image[i]) scratch_image[i] = '0;
    endfunction

    function void report(string what);
      if (errors < MAX_REPORTS) $display("ERROR @%0t: %s", $time, what);
      errors++;
    endfunction

    function int unsigned pending();
      return pending_rsp.size();
    endfunction

    function logic [31:0] merge_lanes(logic [31:0] word, logic [31:0] lanes,
                                      logic [4:0] sh, logic [31:0] wd);
      logic [31:0] m;
      m = lanes << sh;
      return (word & ~m) | ((wd << sh) & m);
    endfunction

    // Decode one access and update the store images the way the block must
    function access_rsp_t decode_access(logic kind, logic [1:0] size,
                                        logic [31:0] va, logic [31:0] wd);
      access_rsp_t       r;
      logic              wr;
      logic [31:0]       phys, lanes, word;
      logic [4:0]        sh;
      int unsigned       idx;
      logic [SCR_AW-1:0] sidx;
      wr = (kind == KIND_WRITE);
      r.read_data = '0;
      r.status = ST_LOCAL;
      r.ext_address = '0;
      r.lane_shift = '0;
      case (size)
        SZ_BYTE: lanes = 32'h0000_00FF;
        SZ_HALF: lanes = 32'h0000_FFFF;
        default: lanes = 32'hFFFF_FFFF;
      endcase
      if (size == SZ_RSVD) begin
        r.status = ST_UNMAPPED;
        r.read_data = wr ? 32'h0 : 32'hFFFF_FFFF;
      end else if ((size == SZ_HALF && va[0]) || (size == SZ_WORD && va[1:0] != 2'b00)) begin
        r.status = ST_MISALIGN;
        r.read_data = wr ? 32'h0 : lanes;
      end else begin
        if (va[31:29] == SEG_KSEG0 || va[31:29] == SEG_KSEG1 || va[31:30] == 2'b00)
          phys = va & PHYS_MASK;
        else
          phys = va;
        case (size)
          SZ_BYTE: sh = {phys[1:0], 3'b000};
          SZ_HALF: sh = {phys[1], 4'b0000};
          default: sh = 5'd0;
        endcase
        if (phys < RAM_END || (phys <= MIRROR_LAST && (wr || size == SZ_WORD))) begin
          idx = ((phys & MIRROR_MASK) >> 2) % RAM_WORDS;
          word = ram_image.exists(idx) ? ram_image[idx] : 32'h0;
          if (wr) ram_image[idx] = merge_lanes(word, lanes, sh, wd);
          else r.read_data = (word >> sh) & lanes;
        end else if (phys >= SCR_BASE && phys < SCR_END) begin
          sidx = SCR_AW'((phys - SCR_BASE) >> 2);
          if (wr) scratch_image[sidx] = merge_lanes(scratch_image[sidx], lanes, sh, wd);
          else r.read_data = (scratch_image[sidx] >> sh) & lanes;
        end else if (phys >= IO_BASE && phys < IO_END) begin
          r.status = ST_IO;
          r.ext_address = phys[28:0] & ~29'd3;
          r.lane_shift = sh;
        end else if (phys >= BIOS_BASE && phys < BIOS_END) begin
          if (wr) begin
            r.status = ST_ROM_WRITE;
          end else begin
            r.status = ST_BIOS_RD;
            r.ext_address = (phys[28:0] - BIOS_BASE[28:0]) & ~29'd3;
            r.lane_shift = sh;
          end
        end else begin
          r.status = ST_UNMAPPED;
          r.read_data = wr ? 32'h0 : lanes;
        end
      end
      return r;
    endfunction

    function void note_request(logic kind, logic [1:0] size, logic [31:0] va,
                               logic [31:0] wd);
      access_rsp_t exp_rsp;
      if (kind == KIND_WRITE) writes++;
      exp_rsp = decode_access(kind, size, va, wd);
      pending_rsp.insert(pending_rsp.size(), exp_rsp);
    endfunction

    function void check_response(logic [31:0] rd, logic [2:0] st, logic [28:0] ext,
                                 logic [4:0] lsh);
      access_rsp_t e;
      if (pending_rsp.size() == 0) begin
        report($sformatf("response with nothing outstanding: data=%h status=%0d", rd, st));
        return;
      end
      e = pending_rsp.pop_front();
      checked++;
      status_seen[e.status]++;
      if (rd !== e.read_data)
        report($sformatf("item %0d read_data %h, want %h", checked, rd, e.read_data));
      if (st !== e.status)
        report($sformatf("item %0d status %0d, want %0d", checked, st, e.status));
      if (ext !== e.ext_address)
        report($sformatf("item %0d ext_address %h, want %h", checked, ext, e.ext_address));
      if (lsh !== e.lane_shift)
        report($sformatf("item %0d lane_shift %0d, want %0d", checked, lsh, e.lane_shift));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        idle_quiet = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned rsp_hold = 0;
  access_ledger ledger = new();

  sbad_req_if req_bus ();
  sbad_rsp_if rsp_bus ();

  segment_bus_access_decoder DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles with %0d responses outstanding",
               cycle_count, ledger.pending());
      $display("segment_bus_access_decoder: mismatch");
      $finish;
    end
  end

  // Mostly short idles, now and then a long one
  function automatic int unsigned idle_len(int unsigned short_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < short_pct) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  // Response side back-pressure
  always @(posedge clk_i) begin
    if (rsp_hold != 0) begin
      rsp_hold <= rsp_hold - 1;
    end else if (idle_quiet || $urandom_range(0, 99) < 60) begin
      rsp_bus.ready <= 1'b1;
      rsp_hold <= $urandom_range(0, 6);
    end else begin
      rsp_bus.ready <= 1'b0;
      rsp_hold <= idle_len(70);
    end
  end

  // Note requests before checking responses so any latency orders correctly
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_bus.valid && req_bus.ready)
        ledger.note_request(req_bus.kind, req_bus.access_size, req_bus.virt_address,
                            req_bus.write_data);
      if (rsp_bus.valid && rsp_bus.ready)
        ledger.check_response(rsp_bus.read_data, rsp_bus.status, rsp_bus.ext_address,
                              rsp_bus.lane_shift);
    end
  end

  task automatic send_access(input logic kind, input logic [1:0] size,
                             input logic [31:0] va, input logic [31:0] wd);
    int unsigned gap;
    gap = idle_quiet ? 0 : ($urandom_range(0, 99) < 50 ? 0 : idle_len(75));
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid        <= 1'b1;
    req_bus.kind         <= kind;
    req_bus.access_size  <= size;
    req_bus.virt_address <= va;
    req_bus.write_data   <= wd;
    do @(posedge clk_i); while (!req_bus.ready);
  endtask

  // Hold the request side until every response is back
  task automatic drain_responses();
    req_bus.valid <= 1'b0;
    do @(posedge clk_i); while (ledger.pending() != 0);
  endtask

  task automatic send_random_access();
    logic        kind;
    logic [1:0]  size;
    logic [31:0] phys;
    logic [31:0] va;
    logic [31:0] seg;
    int unsigned r;
    addr_zone_e  zone;
    kind = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    size = (r < 32) ? SZ_BYTE : (r < 64) ? SZ_HALF : (r < 96) ? SZ_WORD : SZ_RSVD;
    r = $urandom_range(0, 99);
    zone = (r < 30) ? ZONE_RAM : (r < 40) ? ZONE_MIRROR : (r < 55) ? ZONE_SCRATCH :
           (r < 67) ? ZONE_IO : (r < 79) ? ZONE_BIOS : (r < 90) ? ZONE_BOUNDARY : ZONE_ANY;
    case (zone)
      ZONE_RAM:
        phys = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MIRROR_MASK)
                                           : $urandom_range(0, 255);
      ZONE_MIRROR:
        phys = $urandom_range(1, 3) * RAM_END +
               (($urandom_range(0, 9) == 0) ? $urandom_range(0, MIRROR_MASK)
                                            : $urandom_range(0, 255));
      ZONE_SCRATCH: phys = SCR_BASE + $urandom_range(0, SCR_END - SCR_BASE - 1);
      ZONE_IO:      phys = IO_BASE + $urandom_range(0, IO_END - IO_BASE - 1);
      ZONE_BIOS:    phys = BIOS_BASE + $urandom_range(0, BIOS_END - BIOS_BASE - 1);
      ZONE_BOUNDARY: begin
        case ($urandom_range(0, 7))
          0: phys = RAM_END;
          1: phys = MIRROR_LAST + 1;
          2: phys = SCR_BASE;
          3: phys = SCR_END;
          4: phys = IO_BASE;
          5: phys = IO_END;
          6: phys = BIOS_BASE;
          default: phys = BIOS_END;
        endcase
        phys = phys + $urandom_range(0, 15) - 8;
      end
      default: phys = $urandom;
    endcase
    if (zone == ZONE_ANY) begin
      va = phys;
    end else begin
      case ($urandom_range(0, 3))
        0: seg = 32'h0;
        1: seg = KUSEG_HI;
        2: seg = KSEG0_BASE;
        default: seg = KSEG1_BASE;
      endcase
      va = phys | seg;
    end
    // Keep most halves and words aligned; force a bad offset on the rest
    if ($urandom_range(0, 9) != 0) begin
      if (size == SZ_HALF) va[0] = 1'b0;
      if (size == SZ_WORD) va[1:0] = 2'b00;
    end else begin
      if (size == SZ_HALF) va[0] = 1'b1;
      if (size == SZ_WORD) va[1:0] = 2'($urandom_range(1, 3));
    end
    send_access(kind, size, va, $urandom);
  endtask

  initial begin
    rst_ni = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.kind = KIND_READ;
    req_bus.access_size = SZ_BYTE;
    req_bus.virt_address = '0;
    req_bus.write_data = '0;
    rsp_bus.ready = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Lanes and segment masks over main RAM
    send_access(KIND_WRITE, SZ_WORD, 32'h0000_0010, 32'hDEAD_BEEF);
    send_access(KIND_READ,  SZ_BYTE, 32'h8000_0011, 32'h0);
    send_access(KIND_READ,  SZ_HALF, 32'hA000_0012, 32'h0);
    send_access(KIND_WRITE, SZ_BYTE, 32'h0000_0013, 32'hFFFF_FF5A);
    send_access(KIND_READ,  SZ_WORD, 32'h2000_0010, 32'h0);
    // Mirror: writes of any size and word reads land in RAM, narrow reads do not
    send_access(KIND_WRITE, SZ_HALF, 32'h0060_0012, 32'h0000_1234);
    send_access(KIND_READ,  SZ_WORD, 32'h0040_0010, 32'h0);
    send_access(KIND_READ,  SZ_BYTE, 32'h0020_0010, 32'h0);
    send_access(KIND_READ,  SZ_HALF, 32'h007F_FFFE, 32'h0);
    send_access(KIND_WRITE, SZ_WORD, 32'h801F_FFFC, 32'hFFFF_FFFF);
    send_access(KIND_READ,  SZ_WORD, 32'h001F_FFFC, 32'h0);
    // Scratchpad top word
    send_access(KIND_WRITE, SZ_WORD, 32'h1F80_03FC, 32'hA5C3_E187);
    send_access(KIND_READ,  SZ_BYTE, 32'h9F80_03FF, 32'h0);
    // I/O accesses, BIOS reads and ROM write
    send_access(KIND_READ,  SZ_BYTE, 32'h1F80_1003, 32'h0);
    send_access(KIND_WRITE, SZ_HALF, 32'hBF80_1FFE, 32'h0000_BEEF);
    send_access(KIND_READ,  SZ_WORD, 32'hBFC7_FFFC, 32'h0);
    send_access(KIND_READ,  SZ_HALF, 32'h1FC0_0002, 32'h0);
    send_access(KIND_WRITE, SZ_BYTE, 32'h9FC0_0001, 32'h0000_00AA);
    // Misaligned, unmapped and reserved size
    send_access(KIND_READ,  SZ_HALF, 32'h0000_0001, 32'h0);
    send_access(KIND_WRITE, SZ_WORD, 32'h0000_0002, 32'h1111_2222);
    send_access(KIND_READ,  SZ_WORD, 32'hC000_0000, 32'h0);
    send_access(KIND_READ,  SZ_BYTE, 32'h1F80_0400, 32'h0);
    send_access(KIND_WRITE, SZ_WORD, 32'hFFFF_FFFC, 32'h3333_4444);
    send_access(KIND_READ,  SZ_RSVD, 32'h0000_0010, 32'h0);
    send_access(KIND_WRITE, SZ_RSVD, 32'h1F80_1000, 32'h5555_6666);
    drain_responses();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) idle_quiet <= ($urandom_range(0, 3) == 0);
      if (i != 0 && i % 400 == 0) drain_responses();
      send_random_access();
    end
    drain_responses();
    repeat (8) @(posedge clk_i);

    if (ledger.pending() != 0)
      ledger.report($sformatf("%0d responses never arrived", ledger.pending()));
    $display("checked %0d accesses, %0d of them writes", ledger.checked, ledger.writes);
    $display("by status: local %0d, bios %0d, io %0d, misaligned %0d, unmapped %0d, rom %0d",
             ledger.status_seen[ST_LOCAL], ledger.status_seen[ST_BIOS_RD],
             ledger.status_seen[ST_IO], ledger.status_seen[ST_MISALIGN],
             ledger.status_seen[ST_UNMAPPED], ledger.status_seen[ST_ROM_WRITE]);
    if (ledger.errors == 0) begin
      $display("segment_bus_access_decoder: match");
    end else begin
      $display("segment_bus_access_decoder: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/sbad_pkg.sv
rtl/sbad_req_if.sv
rtl/sbad_rsp_if.sv
rtl/sbad_decode.sv
rtl/segment_bus_access_decoder.sv
tb/tb_top.sv
